### rtl/knck_pkg.sv
package knck_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int MAX_KEEP  = 8;
    localparam int DIST_W    = 32;
    localparam int POINT_W   = 31;
    localparam int COUNT_W   = 4;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DIST_W-1:0]  distance_key;
        logic [POINT_W-1:0] point_index;
    } item_t;

    typedef struct packed {
        logic               valid_res;
        logic [DIST_W-1:0]  out_distance;
        logic [POINT_W-1:0] out_point;
        logic [COUNT_W-1:0] kept_count;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [DIST_W-1:0]  key;
        logic [POINT_W-1:0] point;
    } cand_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic  ins;
        logic  rot;
        cand_t cand;
    } cell_ctl_t;

    // True when candidate a ranks behind candidate b.
    function automatic logic worse(input cand_t a, input cand_t b);
        worse = (a.key > b.key) || ((a.key == b.key) && (a.point > b.point));
    endfunction

endpackage

### rtl/k_nearest_candidate_keeper.sv
// Clear and offer transfers can follow back to back. A drain holds item_ready
// low while it runs: one result per cycle while result_ready allows (one for an
// empty set, else one per kept candidate), the first registered after busy_reg
// is set, and each result from a non-empty set rotates the cell chain by one place.
// Reset clears the kept count and sets capacity to 8; slot contents are not reset.
module k_nearest_candidate_keeper #(
    parameter int SLOTS = knck_pkg::SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  knck_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output knck_pkg::res_t                    result,
    input  logic                              cfg_wr_en,
    input  logic [knck_pkg::COUNT_W-1:0]      cfg_wr_data
);
    import knck_pkg::*;

    localparam int NCELL = (SLOTS < MAX_KEEP) ? SLOTS : MAX_KEEP;

    logic [COUNT_W-1:0] cap_reg;
    logic [COUNT_W-1:0] held_reg, held_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic               busy_reg, busy_next;
    logic               result_valid_reg, result_valid_next;
    res_t               result_reg, result_next;

    logic [COUNT_W-1:0] eff_cap;
    logic [COUNT_W-1:0] n_eff;
    logic               full;
    logic               replace_ok;
    logic               do_ins;
    logic               accept;
    logic               load;
    cell_ctl_t          ctl;

    cand_t              cand_w   [NCELL];
    logic [NCELL-1:0]   better_w;
    logic [NCELL-1:0]   take_w;
    logic [NCELL-1:0]   occ_w;
    logic [NCELL-1:0]   tail_w;

    assign item_ready   = !busy_reg;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign load         = busy_reg && (!result_valid_reg || result_ready);

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = COUNT_W'(1);
        else if (cap_reg > COUNT_W'(NCELL))
            eff_cap = COUNT_W'(NCELL);
        else
            eff_cap = cap_reg;
    end

    assign full = (held_reg >= eff_cap);

    // When full, the worst entry is dropped first, so one less slot is occupied.
    assign n_eff = full ? (held_reg - COUNT_W'(1)) : held_reg;

    always_comb
    begin
        replace_ok = 1'b0;
        for (int i = 0; i < NCELL; i++)
        begin
            if ((held_reg != '0) && (COUNT_W'(i) == held_reg - COUNT_W'(1)))
                replace_ok = better_w[i];
        end
    end

    assign do_ins = accept && (item.kind == KIND_OFFER) && (!full || replace_ok);

    assign ctl.ins        = do_ins;
    assign ctl.rot        = load && (held_reg != '0);
    assign ctl.cand.key   = item.distance_key;
    assign ctl.cand.point = item.point_index;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            cand_t l_cand;
            cand_t r_cand;
            logic  l_take;

            assign occ_w[g]  = (COUNT_W'(g) < n_eff);
            assign tail_w[g] = (COUNT_W'(g) == held_reg - COUNT_W'(1));

            if (g == 0)
            begin : g_first
                assign l_cand = cand_w[0];
                assign l_take = 1'b0;
            end
            else
            begin : g_inner
                assign l_cand = cand_w[g-1];
                assign l_take = take_w[g-1];
            end

            if (g == NCELL - 1)
            begin : g_end
                assign r_cand = cand_w[0];
            end
            else
            begin : g_mid
                assign r_cand = cand_w[g+1];
            end

            knck_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occ        (occ_w[g]),
                .tail       (tail_w[g]),
                .left_take  (l_take),
                .left_cand  (l_cand),
                .right_cand (r_cand),
                .head_cand  (cand_w[0]),
                .cand       (cand_w[g]),
                .better     (better_w[g]),
                .take       (take_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        held_next         = held_reg;
        remain_next       = remain_reg;
        busy_next         = busy_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        if (accept)
        begin
            case (item.kind)
                KIND_CLEAR:
                begin
                    held_next = '0;
                end
                KIND_OFFER:
                begin
                    if (do_ins && !full)
                        held_next = held_reg + COUNT_W'(1);
                end
                KIND_DRAIN:
                begin
                    busy_next   = 1'b1;
                    remain_next = (held_reg == '0) ? COUNT_W'(1) : held_reg;
                end
                default:
                begin
                    held_next = held_reg;
                end
            endcase
        end

        if (load)
        begin
            result_valid_next        = 1'b1;
            result_next.valid_res    = (held_reg != '0);
            result_next.out_distance = (held_reg != '0) ? cand_w[0].key : '0;
            result_next.out_point    = (held_reg != '0) ? cand_w[0].point : '0;
            result_next.kept_count   = held_reg;
            result_next.last         = (remain_reg == COUNT_W'(1));
            remain_next              = remain_reg - COUNT_W'(1);
            if (remain_reg == COUNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= COUNT_W'(MAX_KEEP);
            held_reg         <= '0;
            remain_reg       <= '0;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            held_reg         <= held_next;
            remain_reg       <= remain_next;
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= COUNT_W'(NCELL))
        else $error("kept count exceeds the cell count");

    a_busy_remain: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (remain_reg != '0))
        else $error("drain running with nothing left to send");

    a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind == KIND_DRAIN)) |=> busy_reg)
        else $error("drain transfer did not start the drain");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.last) |-> busy_reg)
        else $error("non-final result with no drain running");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.valid_res) |-> result_reg.last)
        else $error("empty-set result not marked last");

endmodule

### rtl/knck_cell.sv
module knck_cell (
    input  logic                clk,
    input  knck_pkg::cell_ctl_t ctl,
    input  logic                occ,
    input  logic                tail,
    input  logic                left_take,
    input  knck_pkg::cand_t     left_cand,
    input  knck_pkg::cand_t     right_cand,
    input  knck_pkg::cand_t     head_cand,
    output knck_pkg::cand_t     cand,
    output logic                better,
    output logic                take
);
    import knck_pkg::*;

    cand_t slot_reg;
    cand_t slot_next;

    assign cand   = slot_reg;
    assign better = worse(slot_reg, ctl.cand);
    // An empty slot always yields to the incoming candidate or the one shifted in.
    assign take   = occ ? better : 1'b1;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.ins && take)
        begin
            slot_next = left_take ? left_cand : ctl.cand;
        end
        else if (ctl.rot)
        begin
            slot_next = tail ? head_cand : right_cand;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule
